### design/nrst_pkg.sv
// shared constants and types of the node reject statistics table
package nrst_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int NCOUNT    = 9;
  localparam int CTR_W     = 16;

  localparam logic [2:0] ACT_REGISTER = 3'd0;
  localparam logic [2:0] ACT_ACCEPTED = 3'd1;
  localparam logic [2:0] ACT_REJECTED = 3'd2;
  localparam logic [2:0] ACT_READ_ID  = 3'd3;
  localparam logic [2:0] ACT_READ_SLT = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  localparam logic [3:0] REASON_OTHER = 4'd8;
  localparam logic [3:0] REASON_NONE  = 4'd9;
  localparam logic [3:0] CTR_ACCEPTED = 4'd8;
  localparam logic [CTR_W-1:0] CTR_MAX = {CTR_W{1'b1}};

  typedef struct packed {
    logic [47:0] mac;
    logic        mac_known;
    logic [31:0] seen;
    logic [31:0] acc_seq;
    logic [31:0] rej_seq;
    logic [3:0]  reason;
  } entry_rec_t;

endpackage

### design/nrst_ram.sv
// generic single-port-write, registered-read ram
module nrst_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [(D>1?$clog2(D):1)-1:0] waddr,
  input  logic [W-1:0]                  wdata,
  input  logic [(D>1?$clog2(D):1)-1:0] raddr,
  output logic [W-1:0]                  rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### design/node_reject_statistics_table_core.sv
// top level of the node reject statistics table
// flow: on acceptance the word is latched and the entry and its counter row are read from
// ram into its read registers; the modify step then registers the result word
// busy: no new word is taken during the read-modify-write of the ram entry or while a result waits
// reset: synchronous active-low rst_n clears the fill count and the handshake
// state; ram contents and stored ids are left as they are and only filled slots are used
module node_reject_statistics_table_core
  import nrst_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [31:0] in_node_id,
  input  logic [47:0] in_mac_in,
  input  logic        in_mac_given,
  input  logic [31:0] in_sequence_number,
  input  logic [3:0]  in_reject_reason,
  input  logic [31:0] in_time_ms,
  input  logic [3:0]  in_slot_select,
  input  logic [3:0]  in_counter_select,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [$clog2(SLOTS+1)-1:0] out_slot,
  output logic [31:0] out_node_out,
  output logic [47:0] out_mac_out,
  output logic        out_mac_known,
  output logic [31:0] out_seen_ms,
  output logic [31:0] out_accepted_seq,
  output logic [31:0] out_rejected_seq,
  output logic [3:0]  out_last_reason,
  output logic [15:0] out_counter_value
);
  localparam int SW   = $clog2(SLOTS+1);
  localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RW   = $bits(entry_rec_t);
  localparam int ROWW = NCOUNT * CTR_W;

  typedef enum logic {S_IDLE, S_MOD} state_t;

  state_t state_r;
  logic [SW-1:0] count_r;
  logic [31:0] node_ids_r [SLOTS];

  // latched word
  logic [2:0]  act_r;
  logic [31:0] id_r;
  logic [47:0] mac_r;
  logic        mg_r;
  logic [31:0] seq_r;
  logic [3:0]  reason_r;
  logic [31:0] time_r;
  logic [3:0]  csel_r;
  logic [IW-1:0] idx_r;
  logic [2:0]  status_r;

  logic out_valid_r;
  logic [2:0]  status_out_r;
  logic [SW-1:0] slot_out_r;
  logic [31:0] node_out_r;
  entry_rec_t  rec_out_r;
  logic [15:0] ctr_out_r;

  // id match over the filled slots, lowest slot wins
  logic [SLOTS-1:0] match;
  logic             found;
  logic [IW-1:0]    found_idx;
  logic [2:0]       status_nxt;
  logic [IW-1:0]    idx_nxt;
  logic [7:0]       ssel_ext;
  logic             accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign ssel_ext = {4'b0, in_slot_select};

  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      match[i] = (node_ids_r[i] == in_node_id) && (SW'(i) < count_r);
      if (match[i]) begin
        found     = 1'b1;
        found_idx = IW'(i);
      end
    end
  end

  // decide the outcome from the incoming word and the id table
  always_comb begin
    status_nxt = ST_OK;
    idx_nxt    = found_idx;
    case (in_action)
      ACT_REGISTER: begin
        idx_nxt = count_r[IW-1:0];
        if (in_node_id == 32'd0) begin
          status_nxt = ST_INVALID;
        end else if (found) begin
          status_nxt = ST_DUP;
        end else if (count_r == SW'(SLOTS)) begin
          status_nxt = ST_FULL;
        end
      end
      ACT_ACCEPTED, ACT_REJECTED, ACT_READ_ID: begin
        if (in_node_id == 32'd0) begin
          status_nxt = ST_INVALID;
        end else if (!found) begin
          status_nxt = ST_NOTFOUND;
        end
      end
      ACT_READ_SLT: begin
        idx_nxt = ssel_ext[IW-1:0];
        if (ssel_ext >= 8'(count_r)) begin
          status_nxt = ST_NOTFOUND;
        end
      end
      default: status_nxt = ST_NOTFOUND;
    endcase
  end

  // entry record and counter row memories
  entry_rec_t rd_rec, rec_nxt;
  logic [ROWW-1:0] rd_row, row_nxt;
  logic [IW-1:0]   raddr;
  logic            we;

  assign raddr = accept ? idx_nxt : idx_r;

  nrst_ram #(.W(RW), .D(SLOTS)) u_rec_ram (
    .clk(clk), .we(we), .waddr(idx_r), .wdata(rec_nxt), .raddr(raddr), .rdata(rd_rec)
  );

  nrst_ram #(.W(ROWW), .D(SLOTS)) u_ctr_ram (
    .clk(clk), .we(we), .waddr(idx_r), .wdata(row_nxt), .raddr(raddr), .rdata(rd_row)
  );

  // modify step on the data read back
  logic [3:0]  rsn;
  logic [3:0]  cidx;
  logic        bump_en;
  logic [15:0] ctr_sel;

  always_comb begin
    rec_nxt = rd_rec;
    row_nxt = rd_row;
    rsn     = (reason_r > REASON_OTHER) ? REASON_OTHER : reason_r;
    cidx    = CTR_ACCEPTED;
    bump_en = 1'b0;
    case (act_r)
      ACT_REGISTER: begin
        rec_nxt        = '0;
        rec_nxt.reason = REASON_NONE;
        row_nxt        = '0;
      end
      ACT_ACCEPTED: begin
        rec_nxt.seen    = time_r;
        rec_nxt.acc_seq = seq_r;
        rec_nxt.reason  = REASON_NONE;
        bump_en         = 1'b1;
      end
      ACT_REJECTED: begin
        rec_nxt.seen    = time_r;
        rec_nxt.rej_seq = seq_r;
        rec_nxt.reason  = rsn;
        cidx            = rsn;
        bump_en         = (rsn < REASON_OTHER);
      end
      default: ;
    endcase
    if ((act_r == ACT_ACCEPTED || act_r == ACT_REJECTED) && mg_r) begin
      rec_nxt.mac       = mac_r;
      rec_nxt.mac_known = 1'b1;
    end
    // saturating bump of the one chosen counter lane
    for (int k = 0; k < NCOUNT; k++) begin
      if (bump_en && cidx == 4'(k) && rd_row[k*CTR_W +: CTR_W] != CTR_MAX) begin
        row_nxt[k*CTR_W +: CTR_W] = rd_row[k*CTR_W +: CTR_W] + 16'd1;
      end
    end
    ctr_sel = '0;
    for (int k = 0; k < NCOUNT; k++) begin
      if (csel_r == 4'(k)) begin
        ctr_sel = row_nxt[k*CTR_W +: CTR_W];
      end
    end
  end

  assign we = (state_r == S_MOD) && (status_r == ST_OK) &&
              (act_r == ACT_REGISTER || act_r == ACT_ACCEPTED || act_r == ACT_REJECTED);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_MOD;
          end
        end
        S_MOD: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
          if (we && act_r == ACT_REGISTER) begin
            count_r <= count_r + SW'(1);
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
    // payload registers
    if (accept) begin
      act_r    <= in_action;
      id_r     <= in_node_id;
      mac_r    <= in_mac_in;
      mg_r     <= in_mac_given;
      seq_r    <= in_sequence_number;
      reason_r <= in_reject_reason;
      time_r   <= in_time_ms;
      csel_r   <= in_counter_select;
      idx_r    <= idx_nxt;
      status_r <= status_nxt;
    end
    if (state_r == S_MOD) begin
      status_out_r <= status_r;
      if (status_r == ST_OK) begin
        slot_out_r <= SW'(idx_r);
        node_out_r <= (act_r == ACT_READ_SLT) ? node_ids_r[idx_r] : id_r;
        rec_out_r  <= rec_nxt;
        ctr_out_r  <= ctr_sel;
      end else begin
        slot_out_r <= SW'(SLOTS);
        node_out_r <= '0;
        rec_out_r  <= '0;
        ctr_out_r  <= '0;
      end
      if (we && act_r == ACT_REGISTER) begin
        node_ids_r[idx_r] <= id_r;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_out_r;
  assign out_slot          = slot_out_r;
  assign out_node_out      = node_out_r;
  assign out_mac_out       = rec_out_r.mac;
  assign out_mac_known     = rec_out_r.mac_known;
  assign out_seen_ms       = rec_out_r.seen;
  assign out_accepted_seq  = rec_out_r.acc_seq;
  assign out_rejected_seq  = rec_out_r.rej_seq;
  assign out_last_reason   = rec_out_r.reason;
  assign out_counter_value = ctr_out_r;

`ifndef SYNTHESIS
  // fill count never passes the table size
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= SW'(SLOTS))
    else $error("fill count beyond table size");
  // an accepted word always goes to the modify step
  assert property (@(posedge clk) disable iff (!rst_n) accept |=> state_r == S_MOD)
    else $error("accepted word not processed");
  // the modify step always leaves a result word
  assert property (@(posedge clk) disable iff (!rst_n) state_r == S_MOD |=> out_valid_r)
    else $error("result word missing");
  // the fill count grows only through a successful register
  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> $past(we && act_r == ACT_REGISTER))
    else $error("fill count changed without register");
`endif
endmodule
